// ===== rtl/rafilt_pkg.sv =====
// ----------------------------------------------------------------------------
// rafilt_pkg: shared types and constants of the running average filter
// Sample width and the status word that the divider hands to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rafilt_pkg;

   // Width of one sample and of one averaged result word.
   localparam int SAMPLE_W = 16;

   // Status of the iterative divider as seen by the top level.
   typedef struct packed {
      logic busy;   // A division is in progress or its quotient waits to be taken.
      logic done;   // The quotient is final and waits to be taken.
   } div_status_type;

endpackage

`default_nettype wire

// ===== rtl/rafilt_cell.sv =====
// ----------------------------------------------------------------------------
// rafilt_cell: one stage of the sample delay line
// Holds one sample and passes it to the next cell when a new word enters.
// ----------------------------------------------------------------------------
`default_nettype none

module rafilt_cell (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    shift_en,
   input  wire logic signed [rafilt_pkg::SAMPLE_W-1:0]  data_in,
   output logic signed [rafilt_pkg::SAMPLE_W-1:0]       data_out
);

   logic signed [rafilt_pkg::SAMPLE_W-1:0] slot_ff;
   logic signed [rafilt_pkg::SAMPLE_W-1:0] slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (shift_en) begin
         slot_in = data_in;
      end
   end

   // Empty slots must read as zero so that they add nothing during warm-up.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign data_out = slot_ff;

endmodule

`default_nettype wire

// ===== rtl/rafilt_div.sv =====
// ----------------------------------------------------------------------------
// rafilt_div: bit-serial signed divider
// Restoring division of the window sum by the fill count, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rafilt_div #(
   parameter int SUM_W = 21,
   parameter int CNT_W = 5
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   input  wire logic signed [SUM_W-1:0]                 dividend,
   input  wire logic [CNT_W-1:0]                        divisor,
   input  wire logic                                    take,
   output rafilt_pkg::div_status_type                   status,
   output logic signed [rafilt_pkg::SAMPLE_W-1:0]       quotient
);

   localparam int STEP_W = $clog2(SUM_W);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic              neg_ff, neg_in;

   logic [CNT_W:0]    trial;
   logic              fits;
   logic [SUM_W-1:0]  signed_quo;

   // One restoring step: shift in the next dividend bit and try to subtract.
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in   = dividend[SUM_W-1];
               quo_in   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
               rem_in   = '0;
               div_in   = divisor;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (fits) begin
               rem_in = CNT_W'(trial - {1'b0, div_ff});
            end else begin
               rem_in = trial[CNT_W-1:0];
            end
            quo_in  = {quo_ff[SUM_W-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
   end

   // The mean of 16-bit samples always fits in 16 bits after the sign fix.
   assign signed_quo  = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient    = signed_quo[rafilt_pkg::SAMPLE_W-1:0];
   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_DONE);

endmodule

`default_nettype wire

// ===== rtl/running_average_filter.sv =====
// ----------------------------------------------------------------------------
// running_average_filter: moving average of the last WINDOW samples with warm-up
// A result word passes through the sum register, the divider and the output register;
// a new sample is taken only once the last quotient has been handed to the output register.
// Reset is synchronous and clears the sample cells, sum and fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module running_average_filter #(
   parameter int WINDOW = 20
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic signed [rafilt_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [rafilt_pkg::SAMPLE_W-1:0]       rsp_average
);

   // The sum of WINDOW signed samples needs log2(WINDOW) bits of growth.
   // The fill count must be able to hold WINDOW itself.
   localparam int SUM_W = rafilt_pkg::SAMPLE_W + $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);

   // The sample history is a chain of cells. A new word enters the first
   // cell and every cell hands its sample to the next one, so the last cell
   // always holds the sample that is about to leave the window. This stands
   // in for a ring buffer with a write pointer: the oldest slot is always at
   // the end of the chain.
   logic signed [rafilt_pkg::SAMPLE_W-1:0] cell_data [WINDOW];
   logic                                   accept;

   assign accept = req_valid && !req_stall;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_first
         rafilt_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (accept),
            .data_in  (req_sample),
            .data_out (cell_data[i])
         );
      end else begin : g_next
         rafilt_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (accept),
            .data_in  (cell_data[i-1]),
            .data_out (cell_data[i])
         );
      end
   end

   // Running sum and fill count. Before the window is full the cells that
   // were never written hold zero, so the sum is the sum of the words seen
   // so far and the count is how many there were.
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    busy_ff, busy_in;
   logic                    start_ff, start_in;

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         sum_in = sum_ff
                - SUM_W'(cell_data[WINDOW-1])
                + SUM_W'(req_sample);
         if (count_ff != CNT_W'(WINDOW)) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // The divider is started on the updated sum in the cycle after the sample enters.
   rafilt_pkg::div_status_type              div_status;
   logic signed [rafilt_pkg::SAMPLE_W-1:0] div_quotient;
   logic                                    take;

   rafilt_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .take     (take),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // The output register decouples the result side: the finished quotient
   // moves into it as soon as it is empty or being read, and that frees the
   // input side for the next sample even while the word waits downstream.
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [rafilt_pkg::SAMPLE_W-1:0] rsp_average_ff, rsp_average_in;

   assign take = div_status.done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_average_in = rsp_average_ff;
      if (take) begin
         rsp_valid_in   = 1'b1;
         rsp_average_in = div_quotient;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // One sample is in flight at a time: the input stalls from acceptance
   // until its quotient has been handed to the output register.
   always_comb begin
      busy_in  = busy_ff;
      start_in = accept;
      if (accept) begin
         busy_in = 1'b1;
      end else if (take) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_average_ff <= rsp_average_in;
   end

   assign req_stall   = busy_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

`ifndef NO_ASSERTIONS
   // The divider only starts while it is idle.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> !div_status.busy)
      else $error("divider started while busy");

   // A finished quotient only exists for a sample still counted as in flight.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> busy_ff)
      else $error("quotient ready with no sample in flight");

   // A handed-over quotient is visible on the result side in the next cycle.
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("result word lost after hand-over");

   // The divisor is never zero while the divider is busy.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (count_ff != '0))
      else $error("division with an empty window");

   // The fill count saturates at the window length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      accept |=> (count_ff <= CNT_W'(WINDOW)) && (count_ff != '0))
      else $error("fill count out of range");
`endif

endmodule

`default_nettype wire
